[hw/rtl/utrd_pkg.sv]
// ----------------------------------------------------------------------------
// UART transmit ring DMA scheduler package
// Shared sizes, command codes and transaction payload types.
// ----------------------------------------------------------------------------
package utrd_pkg;

    localparam int BUF_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int SIZE_W    = 16;

    typedef enum logic [1:0] {
        CMD_APPEND     = 2'd0,
        CMD_BURST_DONE = 2'd1,
        CMD_READ       = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        data_byte;
        logic              first_byte;
        logic [SIZE_W-1:0] message_size;
        logic [ADDR_W-1:0] read_addr;
    } req_t;

    typedef struct packed {
        logic              accepted;
        logic              rejected;
        logic              burst_start;
        logic [ADDR_W-1:0] burst_addr;
        logic [CNT_W-1:0]  burst_len;
        logic [7:0]        read_data;
        logic [CNT_W-1:0]  free_space;
        logic              sending;
    } rsp_t;

endpackage

[hw/rtl/utrd_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one command transaction.
// ----------------------------------------------------------------------------
interface utrd_req_if
    import utrd_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/utrd_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel that carries one status transaction.
// ----------------------------------------------------------------------------
interface utrd_rsp_if
    import utrd_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/utrd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module utrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/uart_tx_ring_dma_scheduler.sv]
// ----------------------------------------------------------------------------
// UART transmit ring DMA scheduler
// Stores message bytes in a ring buffer and issues DMA bursts over it.
// ----------------------------------------------------------------------------
// Each request transaction produces exactly one response transaction. The
// pointers and counters are updated and the byte store is written in the
// accept cycle, and the response is formed in the next cycle, when the
// registered read data of the byte store RAM is available. A new request is
// taken only when no response is being formed and the response register is
// free or being emptied, so a request is not taken while the previous one is
// still being formed. The byte store has no reset; reading a position never
// written returns an arbitrary byte.
module uart_tx_ring_dma_scheduler
    import utrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    utrd_req_if.sink   req,
    utrd_rsp_if.source rsp
);

    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    // Ring state.
    logic [ADDR_W-1:0] fill_pos_reg, fill_pos_next;
    logic [ADDR_W-1:0] committed_end_reg, committed_end_next;
    logic [ADDR_W-1:0] drain_pos_reg, drain_pos_next;
    logic [CNT_W-1:0]  pending_reg, pending_next;
    logic [CNT_W-1:0]  inflight_reg, inflight_next;
    logic              idle_reg, idle_next;
    logic [SIZE_W-1:0] bytes_left_reg, bytes_left_next;
    logic              dropping_reg, dropping_next;

    // Handshake control.
    logic busy_reg;
    logic out_valid_reg;
    logic is_read_reg;
    rsp_t hold_reg;
    rsp_t out_reg;
    rsp_t out_next;

    logic accept;
    logic store_en;
    logic commit_now;
    logic issue_now;
    rsp_t result;

    logic [ADDR_W-1:0] staged;
    logic [CNT_W-1:0]  staged_len;
    logic [CNT_W:0]    pending_sum;
    logic [CNT_W-1:0]  free_now;
    logic [CNT_W:0]    drain_sum;
    logic [7:0]        ram_q;

    function automatic logic [CNT_W-1:0] burst_len_f(
        input logic [ADDR_W-1:0] ce,
        input logic [ADDR_W-1:0] dp
    );
        logic [CNT_W-1:0] len;
        if (ce > dp)
        begin
            len = {1'b0, ce} - {1'b0, dp};
        end
        else
        begin
            len = CNT_W'(BUF_DEPTH) - {1'b0, dp};
        end
        return len;
    endfunction

    assign req.ready = !busy_reg && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        fill_pos_next      = fill_pos_reg;
        committed_end_next = committed_end_reg;
        drain_pos_next     = drain_pos_reg;
        pending_next       = pending_reg;
        inflight_next      = inflight_reg;
        idle_next          = idle_reg;
        bytes_left_next    = bytes_left_reg;
        dropping_next      = dropping_reg;
        store_en           = 1'b0;
        commit_now         = 1'b0;
        issue_now          = 1'b0;
        staged             = '0;
        staged_len         = '0;
        pending_sum        = '0;
        drain_sum          = '0;
        result             = '0;
        free_now           = CNT_W'(BUF_DEPTH) - pending_reg;

        case (req.data.command)
            CMD_APPEND:
            begin
                if (req.data.first_byte)
                begin
                    fill_pos_next   = committed_end_reg;
                    dropping_next   = 1'b0;
                    bytes_left_next = '0;
                    if (req.data.message_size != '0)
                    begin
                        bytes_left_next = req.data.message_size - 1'b1;
                        if (CMP_W'(free_now) < CMP_W'(req.data.message_size))
                        begin
                            result.rejected = 1'b1;
                            dropping_next   = (bytes_left_next != '0);
                        end
                        else
                        begin
                            store_en        = 1'b1;
                            result.accepted = 1'b1;
                            commit_now      = (bytes_left_next == '0);
                        end
                    end
                end
                else if (bytes_left_reg != '0)
                begin
                    bytes_left_next = bytes_left_reg - 1'b1;
                    if (dropping_reg)
                    begin
                        if (bytes_left_next == '0)
                        begin
                            dropping_next = 1'b0;
                        end
                    end
                    else
                    begin
                        store_en        = 1'b1;
                        result.accepted = 1'b1;
                        commit_now      = (bytes_left_next == '0);
                    end
                end
            end
            CMD_BURST_DONE:
            begin
                if (!idle_reg)
                begin
                    pending_next = (pending_reg > inflight_reg) ?
                                   pending_reg - inflight_reg : '0;
                    drain_sum = {2'b00, drain_pos_reg} + {1'b0, inflight_reg};
                    drain_pos_next = (drain_sum >= (CNT_W+1)'(BUF_DEPTH)) ?
                                     '0 : drain_sum[ADDR_W-1:0];
                    if (pending_next != '0)
                    begin
                        issue_now = 1'b1;
                    end
                    else
                    begin
                        idle_next     = 1'b1;
                        inflight_next = '0;
                        if (bytes_left_reg == '0 || dropping_reg)
                        begin
                            fill_pos_next      = '0;
                            committed_end_next = '0;
                            drain_pos_next     = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (store_en)
        begin
            fill_pos_next = fill_pos_next + 1'b1;
        end

        // Committing the last byte moves the staged span into the pending count.
        if (commit_now)
        begin
            staged      = fill_pos_next - committed_end_reg;
            staged_len  = (staged == '0) ? CNT_W'(BUF_DEPTH) : {1'b0, staged};
            pending_sum = {1'b0, pending_reg} + {1'b0, staged_len};
            pending_next = (pending_sum > (CNT_W+1)'(BUF_DEPTH)) ?
                           CNT_W'(BUF_DEPTH) : pending_sum[CNT_W-1:0];
            committed_end_next = fill_pos_next;
            if (idle_reg)
            begin
                idle_next = 1'b0;
                issue_now = 1'b1;
            end
        end

        if (issue_now)
        begin
            inflight_next      = burst_len_f(committed_end_next, drain_pos_next);
            result.burst_start = 1'b1;
            result.burst_addr  = drain_pos_next;
            result.burst_len   = inflight_next;
        end

        result.free_space = CNT_W'(BUF_DEPTH) - pending_next;
        result.sending    = !idle_next;
    end

    utrd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_byte_store (
        .clk     (clk),
        .wr_en   (accept && store_en),
        .wr_addr (fill_pos_next - 1'b1),
        .wr_data (req.data.data_byte),
        .rd_en   (accept),
        .rd_addr (req.data.read_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_pos_reg      <= '0;
            committed_end_reg <= '0;
            drain_pos_reg     <= '0;
            pending_reg       <= '0;
            inflight_reg      <= '0;
            idle_reg          <= 1'b1;
            bytes_left_reg    <= '0;
            dropping_reg      <= 1'b0;
            busy_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_pos_reg      <= fill_pos_next;
                committed_end_reg <= committed_end_next;
                drain_pos_reg     <= drain_pos_next;
                pending_reg       <= pending_next;
                inflight_reg      <= inflight_next;
                idle_reg          <= idle_next;
                bytes_left_reg    <= bytes_left_next;
                dropping_reg      <= dropping_next;
            end
            busy_reg <= accept;
            if (busy_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        out_next           = hold_reg;
        out_next.read_data = is_read_reg ? ram_q : 8'd0;
    end

    // The response waits in the hold register until the RAM read data is available.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg    <= result;
            is_read_reg <= (req.data.command == CMD_READ);
        end
        if (busy_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the UART transmit ring DMA scheduler
// A short table of directed commands is followed by a long random mix of
// messages, burst-done events, reads and no-ops.
// Every request is run through a local model of the ring and its scheduler.
// Each status transaction is checked field by field against that model or, for typed rows, the table.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import utrd_pkg::*;

    localparam int RANDOM_ITEMS = 730;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        cmd_t              cmd;
        logic [7:0]        data;
        logic              first;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        rsp_t              want;
    } plan_row_t;

    localparam rsp_t IDLE_STATUS = '{1'b0, 1'b0, 1'b0, 10'd0, 11'd0, 8'd0, 11'd1024, 1'b0};

    // Rows with typed set carry their expected status; the rest use the model.
    plan_row_t plan [19] = '{
        '{CMD_NOP,        8'h00, 1'b0, 16'd0,     10'd0,     1'b1, IDLE_STATUS},
        '{CMD_BURST_DONE, 8'h00, 1'b0, 16'd0,     10'd0,     1'b1, IDLE_STATUS},
        '{CMD_APPEND,     8'hFF, 1'b0, 16'd0,     10'd0,     1'b1, IDLE_STATUS},
        '{CMD_APPEND,     8'hFF, 1'b1, 16'd0,     10'h3FF,   1'b1, IDLE_STATUS},
        '{CMD_APPEND,     8'hFF, 1'b1, 16'hFFFF,  10'd0,     1'b1,
          '{1'b0, 1'b1, 1'b0, 10'd0, 11'd0, 8'd0, 11'd1024, 1'b0}},
        '{CMD_APPEND,     8'hAA, 1'b0, 16'd0,     10'd0,     1'b1, IDLE_STATUS},
        '{CMD_APPEND,     8'hFF, 1'b1, 16'd1,     10'd0,     1'b1,
          '{1'b1, 1'b0, 1'b1, 10'd0, 11'd1, 8'd0, 11'd1023, 1'b1}},
        '{CMD_READ,       8'h00, 1'b0, 16'd0,     10'd0,     1'b1,
          '{1'b0, 1'b0, 1'b0, 10'd0, 11'd0, 8'hFF, 11'd1023, 1'b1}},
        '{CMD_APPEND,     8'h00, 1'b1, 16'd3,     10'd0,     1'b0, '0},
        '{CMD_APPEND,     8'h5A, 1'b0, 16'd0,     10'd0,     1'b0, '0},
        '{CMD_APPEND,     8'hA5, 1'b1, 16'd2,     10'd0,     1'b0, '0},
        '{CMD_APPEND,     8'h3C, 1'b0, 16'd0,     10'd0,     1'b0, '0},
        '{CMD_READ,       8'h00, 1'b0, 16'd0,     10'd2,     1'b0, '0},
        '{CMD_BURST_DONE, 8'h00, 1'b0, 16'd0,     10'd0,     1'b0, '0},
        '{CMD_APPEND,     8'h11, 1'b1, 16'd1024,  10'd0,     1'b0, '0},
        '{CMD_BURST_DONE, 8'h00, 1'b0, 16'd0,     10'd0,     1'b0, '0},
        '{CMD_BURST_DONE, 8'h00, 1'b0, 16'd0,     10'd0,     1'b0, '0},
        '{CMD_READ,       8'h00, 1'b0, 16'd0,     10'd1,     1'b0, '0},
        '{CMD_NOP,        8'hFF, 1'b1, 16'hFFFF,  10'h3FF,   1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    utrd_req_if req_ch ();
    utrd_rsp_if rsp_ch ();

    uart_tx_ring_dma_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #10ns clk = ~clk;

    // Local image of the ring and its scheduler.
    bit [7:0]          ring_bytes [BUF_DEPTH];
    bit                ring_written [BUF_DEPTH];
    int                written_addrs [$];
    bit [ADDR_W-1:0]   fill_ptr   = '0;
    bit [ADDR_W-1:0]   commit_ptr = '0;
    bit [ADDR_W-1:0]   drain_ptr  = '0;
    bit [CNT_W-1:0]    pending_cnt  = '0;
    bit [CNT_W-1:0]    inflight_cnt = '0;
    bit                ring_idle  = 1'b1;
    bit [SIZE_W-1:0]   msg_left   = '0;
    bit                discarding = 1'b0;

    rsp_t status_q [$];
    rsp_t want_status;
    int   mismatches = 0;
    int   cycles = 0;
    bit   hold_request = 1'b0;

    function automatic rsp_t launch_burst(rsp_t s);
        if (commit_ptr > drain_ptr)
            inflight_cnt = CNT_W'(commit_ptr) - CNT_W'(drain_ptr);
        else
            inflight_cnt = CNT_W'(BUF_DEPTH) - CNT_W'(drain_ptr);
        s.burst_start = 1'b1;
        s.burst_addr  = drain_ptr;
        s.burst_len   = inflight_cnt;
        return s;
    endfunction

    function automatic void put_byte(bit [7:0] b);
        ring_bytes[fill_ptr] = b;
        if (!ring_written[fill_ptr])
        begin
            ring_written[fill_ptr] = 1'b1;
            written_addrs.push_back(int'(fill_ptr));
        end
        fill_ptr = fill_ptr + 1'b1;
    endfunction

    function automatic rsp_t commit_msg(rsp_t s);
        bit [ADDR_W-1:0] diff;
        int              total;
        diff = fill_ptr - commit_ptr;
        // A zero distance means the message filled the whole ring.
        total = int'(pending_cnt) + ((diff == 0) ? BUF_DEPTH : int'(diff));
        pending_cnt = CNT_W'((total > BUF_DEPTH) ? BUF_DEPTH : total);
        commit_ptr = fill_ptr;
        if (ring_idle)
        begin
            ring_idle = 1'b0;
            s = launch_burst(s);
        end
        return s;
    endfunction

    function automatic rsp_t predict_status(req_t r);
        rsp_t s;
        int   sum;
        s = '0;
        case (r.command)
            CMD_APPEND:
            begin
                if (r.first_byte)
                begin
                    fill_ptr   = commit_ptr;
                    discarding = 1'b0;
                    msg_left   = '0;
                    if (r.message_size != 0)
                    begin
                        msg_left = r.message_size - 1'b1;
                        if (BUF_DEPTH - int'(pending_cnt) < int'(r.message_size))
                        begin
                            s.rejected = 1'b1;
                            discarding = (msg_left != 0);
                        end
                        else
                        begin
                            put_byte(r.data_byte);
                            s.accepted = 1'b1;
                            if (msg_left == 0)
                                s = commit_msg(s);
                        end
                    end
                end
                else if (msg_left != 0)
                begin
                    msg_left = msg_left - 1'b1;
                    if (discarding)
                    begin
                        if (msg_left == 0)
                            discarding = 1'b0;
                    end
                    else
                    begin
                        put_byte(r.data_byte);
                        s.accepted = 1'b1;
                        if (msg_left == 0)
                            s = commit_msg(s);
                    end
                end
            end
            CMD_BURST_DONE:
            begin
                if (!ring_idle)
                begin
                    pending_cnt = (pending_cnt > inflight_cnt) ? pending_cnt - inflight_cnt : '0;
                    sum = int'(drain_ptr) + int'(inflight_cnt);
                    drain_ptr = (sum >= BUF_DEPTH) ? '0 : ADDR_W'(sum);
                    if (pending_cnt != 0)
                        s = launch_burst(s);
                    else
                    begin
                        ring_idle    = 1'b1;
                        inflight_cnt = '0;
                        // Pointers are kept while a message is still being staged.
                        if (msg_left == 0 || discarding)
                        begin
                            fill_ptr   = '0;
                            commit_ptr = '0;
                            drain_ptr  = '0;
                        end
                    end
                end
            end
            CMD_READ:
                s.read_data = ring_bytes[r.read_addr];
            default:
                ;
        endcase
        s.free_space = CNT_W'(BUF_DEPTH) - pending_cnt;
        s.sending    = !ring_idle;
        return s;
    endfunction

    function automatic req_t make_req(cmd_t c, bit [7:0] d, bit f, bit [SIZE_W-1:0] sz,
                                      bit [ADDR_W-1:0] a);
        req_t r;
        r.command      = c;
        r.data_byte    = d;
        r.first_byte   = f;
        r.message_size = sz;
        r.read_addr    = a;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit [ADDR_W-1:0] pick_written();
        return ADDR_W'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Offers one request, records its expected status once it is taken,
    // then may leave the channel idle for a random gap drawn by pick_gap.
    task automatic send_req(req_t r, bit typed, rsp_t typed_want);
        rsp_t p;
        int   gap;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        p = predict_status(r);
        status_q.push_back(typed ? typed_want : p);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            req_ch.data  <= req_t'({$urandom, $urandom});
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic send_side();
        if ($urandom_range(0, 1) == 0 || written_addrs.size() == 0)
            send_req(make_req(CMD_BURST_DONE, 8'($urandom), 1'($urandom), 16'($urandom),
                              10'($urandom)), 1'b0, '0);
        else
            send_req(make_req(CMD_READ, 8'($urandom), 1'($urandom), 16'($urandom),
                              pick_written()), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (status_q.size() == 0)
            begin
                $error("status transaction arrived with none expected");
                mismatches++;
            end
            else
            begin
                want_status = status_q.pop_front();
                check_field("accepted", 16'(want_status.accepted),
                            16'(rsp_ch.data.accepted));
                check_field("rejected", 16'(want_status.rejected),
                            16'(rsp_ch.data.rejected));
                check_field("burst_start", 16'(want_status.burst_start),
                            16'(rsp_ch.data.burst_start));
                check_field("burst_addr", 16'(want_status.burst_addr),
                            16'(rsp_ch.data.burst_addr));
                check_field("burst_len", 16'(want_status.burst_len),
                            16'(rsp_ch.data.burst_len));
                check_field("read_data", 16'(want_status.read_data),
                            16'(rsp_ch.data.read_data));
                check_field("free_space", 16'(want_status.free_space),
                            16'(rsp_ch.data.free_space));
                check_field("sending", 16'(want_status.sending),
                            16'(rsp_ch.data.sending));
            end
        end
    end

    // Status receiver: random stalls, plus one long hold that backs up the request channel.
    initial
    begin
        int held;
        int stall;
        rsp_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 20))
                    @(negedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall)
                        @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        int i;
        int k;
        int nb;
        int sz;
        int act;
        int made;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rst_n = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 19; i++)
            send_req(make_req(plan[i].cmd, plan[i].data, plan[i].first, plan[i].size,
                              plan[i].addr), plan[i].typed, plan[i].want);

        // The receiver holds off for a long stretch while requests keep coming.
        hold_request = 1'b1;

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            act = $urandom_range(0, 99);
            if (act < 50)
            begin
                k = $urandom_range(0, 99);
                if (k < 70)
                    sz = $urandom_range(1, 6);
                else if (k < 88)
                    sz = $urandom_range(7, 40);
                else if (k < 94)
                    sz = BUF_DEPTH - int'(pending_cnt) + $urandom_range(1, 8);
                else
                    sz = $urandom_range(1, 65535);
                // Refused messages longer than 12 bytes are cut short to at most 10 bytes.
                nb = (sz > BUF_DEPTH - int'(pending_cnt) && sz > 12) ? $urandom_range(1, 10) : sz;
                for (k = 0; k < nb; k++)
                begin
                    if (k > 0 && $urandom_range(0, 29) == 0)
                        break;
                    if (k > 0 && $urandom_range(0, 9) == 0)
                    begin
                        send_side();
                        made++;
                    end
                    send_req(make_req(CMD_APPEND, 8'($urandom), k == 0,
                                      (k == 0) ? 16'(sz) : 16'($urandom), 10'($urandom)),
                             1'b0, '0);
                    made++;
                end
            end
            else if (act < 90)
            begin
                send_side();
                made++;
            end
            else if (act < 95)
            begin
                send_req(make_req(CMD_NOP, 8'($urandom), 1'($urandom), 16'($urandom),
                                  10'($urandom)), 1'b0, '0);
                made++;
            end
            else if (msg_left == 0)
            begin
                send_req(make_req(CMD_APPEND, 8'($urandom), 1'b0, 16'($urandom),
                                  10'($urandom)), 1'b0, '0);
                made++;
            end
            else
            begin
                send_req(make_req(CMD_APPEND, 8'($urandom), 1'b1, 16'd0, 10'($urandom)),
                         1'b0, '0);
                made++;
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[uart_tx_ring_dma_scheduler.f]
hw/rtl/utrd_pkg.sv
hw/rtl/utrd_req_if.sv
hw/rtl/utrd_rsp_if.sv
hw/rtl/utrd_ram.sv
hw/rtl/uart_tx_ring_dma_scheduler.sv
test/tb.sv
